/* hw/rtl/flash_file_header_scanner_defines.svh */
// Assertion macros for the flash file header scanner top level.
`ifndef FLASH_FILE_HEADER_SCANNER_DEFINES_SVH
`define FLASH_FILE_HEADER_SCANNER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define FHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/fhs_pkg.sv */
// Shared types, constants and CRC helpers for the flash file header scanner.
package fhs_pkg;

  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned MAX_FILES    = 32;
  localparam int unsigned HDR_BYTES    = 64;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] MAGIC_A  = 32'h3231_3035;
  localparam logic [31:0] MAGIC_B  = 32'h0053_4648;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_WORD  = 2'd1;
  localparam logic [1:0] FUNC_FAIL  = 2'd2;

  localparam logic [1:0] ST_READ = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic REG_RESERVED_BASE  = 1'b0;
  localparam logic REG_FORMAT_VERSION = 1'b1;

  localparam logic [3:0] WORD_MAGIC_A  = 4'd0;
  localparam logic [3:0] WORD_MAGIC_B  = 4'd1;
  localparam logic [3:0] WORD_VERSION  = 4'd2;
  localparam logic [3:0] WORD_SIZE     = 4'd3;
  localparam logic [3:0] WORD_CRC      = 4'd4;
  localparam logic [3:0] WORD_FLAGS    = 4'd5;
  localparam logic [3:0] WORD_HDR_CRC  = 4'd15;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] data_word;
    logic [31:0] device_size;
    logic        device_present;
  } req_t;

  typedef struct packed {
    logic [1:0]  scan_status;
    logic [32:0] next_addr;
    logic        entry_recorded;
    logic [4:0]  entry_index;
    logic [31:0] entry_header_addr;
    logic [32:0] entry_data_addr;
    logic [31:0] entry_size;
    logic [31:0] entry_crc;
    logic [5:0]  file_count;
    logic [32:0] free_base;
    logic [31:0] used_total;
  } res_t;

  typedef logic [31:0][31:0] crc_mat_t;

  // Column i is the 32-shift CRC remainder of a lone one in bit i.
  function automatic crc_mat_t crc_build();
    crc_mat_t    m;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'd1 << i;
      for (int k = 0; k < 32; k++) begin
        c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      m[i] = c;
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_build();

  // One 32-bit reflected CRC step as a flat XOR matrix.
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [31:0] w);
    logic [31:0] d;
    logic [31:0] r;
    d = c ^ w;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (d[i]) r = r ^ CRC_MAT[i];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/flash_file_header_scanner.sv */
// A request is registered, then its result is registered and raises out_valid.
// Throughput: one request per cycle; the only hold-off is a full result register under stall.
// A header costs 16 word requests; only the last one (and start / read failure) yields a result.
// Reset: synchronous, active-low rst_n clears the pipeline valids and all scan state and
// loads reserved_base = 0xFF0000 and format_version = 1.
// Top level of the flash file header scanner.
module flash_file_header_scanner (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_data_word,
  input  logic [31:0] in_device_size,
  input  logic        in_device_present,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_scan_status,
  output logic [32:0] out_next_addr,
  output logic        out_entry_recorded,
  output logic [4:0]  out_entry_index,
  output logic [31:0] out_entry_header_addr,
  output logic [32:0] out_entry_data_addr,
  output logic [31:0] out_entry_size,
  output logic [31:0] out_entry_crc,
  output logic [5:0]  out_file_count,
  output logic [32:0] out_free_base,
  output logic [31:0] out_used_total
);
  import fhs_pkg::*;

  `include "flash_file_header_scanner_defines.svh"

  req_t in_req;
  req_t s1_req;
  logic s1_valid;
  logic take;
  logic res_load;
  logic out_ready;
  res_t res_nxt;
  res_t res_q;

  // Bundle the request fields.
  assign in_req.func           = in_func;
  assign in_req.data_word      = in_data_word;
  assign in_req.device_size    = in_device_size;
  assign in_req.device_present = in_device_present;

  // Hold each request here until the core can retire it.
  fhs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  // Advance the scan: CRC step, field checks, sector stepping and table bookkeeping.
  // A request that yields no result retires even while the result register is stalled.
  fhs_scan_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_valid  (s1_valid),
    .s1_req    (s1_req),
    .out_ready (out_ready),
    .take      (take),
    .res_load  (res_load),
    .res       (res_nxt)
  );

  // Hold the result until the consumer drops stall.
  fhs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res_in    (res_nxt),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_scan_status       = res_q.scan_status;
  assign out_next_addr         = res_q.next_addr;
  assign out_entry_recorded    = res_q.entry_recorded;
  assign out_entry_index       = res_q.entry_index;
  assign out_entry_header_addr = res_q.entry_header_addr;
  assign out_entry_data_addr   = res_q.entry_data_addr;
  assign out_entry_size        = res_q.entry_size;
  assign out_entry_crc         = res_q.entry_crc;
  assign out_file_count        = res_q.file_count;
  assign out_free_base         = res_q.free_base;
  assign out_used_total        = res_q.used_total;

  // A recorded entry sits in the slot just below the updated count.
  `FHS_ASSERT(a_entry_slot, (out_valid && out_entry_recorded) |-> (out_file_count == 6'(out_entry_index) + 6'd1), "recorded slot does not match file count")
  // The table never holds more than its capacity.
  `FHS_ASSERT(a_count_cap, out_valid |-> (out_file_count <= 6'(MAX_FILES)), "file count above table size")
  // Reset empties the result register.
  `FHS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

/* hw/rtl/fhs_in_reg.sv */
// Input request register of the flash file header scanner.
module fhs_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fhs_pkg::req_t in_req,
  input  logic          take,
  output logic          s1_valid,
  output fhs_pkg::req_t s1_req
);
  import fhs_pkg::*;

  logic valid_r, valid_nxt;
  req_t req_r;
  logic accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b0;
    if (accept) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  assign s1_valid = valid_r;
  assign s1_req   = req_r;

endmodule

/* hw/rtl/fhs_scan_core.sv */
// Scan state, header checks and result formation of the flash file header scanner.
module fhs_scan_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          s1_valid,
  input  fhs_pkg::req_t s1_req,
  input  logic          out_ready,
  output logic          take,
  output logic          res_load,
  output fhs_pkg::res_t res
);
  import fhs_pkg::*;

  localparam logic [33:0] SECT_MASK = 34'(SECTOR_BYTES - 1);

  logic [31:0] rsv_base_r, fmt_ver_r;
  logic [32:0] addr_r, addr_nxt;
  logic [31:0] limit_r, limit_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] pcrc_r, pcrc_nxt;
  logic [31:0] flags_r, flags_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [32:0] free_r, free_nxt;
  logic [31:0] used_r, used_nxt;
  logic        scan_r, scan_nxt;

  logic        has_res;
  logic        hdr_valid;
  logic        rec;
  logic [31:0] w;
  logic [31:0] clip;
  logic [33:0] ext;
  logic [33:0] addr_ext;
  logic [1:0]  status;

  assign w    = s1_req.data_word;
  assign clip = (s1_req.device_size > rsv_base_r) ? rsv_base_r : s1_req.device_size;

  // Sector extent of a valid file: header plus payload rounded up to whole sectors.
  assign ext      = ({2'b00, size_r} + 34'(HDR_BYTES) + SECT_MASK) & ~SECT_MASK;
  assign addr_ext = {1'b0, addr_r} + ext;

  assign hdr_valid = ok_r && (w == ~crc_r) && (size_r <= rsv_base_r);
  assign rec = hdr_valid && (flags_r == 32'hFFFF_FFFF) && (count_r < 6'(MAX_FILES));

  always_comb begin
    case (s1_req.func)
      FUNC_START: has_res = 1'b1;
      FUNC_FAIL:  has_res = scan_r;
      FUNC_WORD:  has_res = scan_r && (widx_r == WORD_HDR_CRC);
      default:    has_res = 1'b0;
    endcase
  end

  assign take     = s1_valid && (!has_res || out_ready);
  assign res_load = take && has_res;

  always_comb begin
    addr_nxt  = addr_r;
    limit_nxt = limit_r;
    widx_nxt  = widx_r;
    crc_nxt   = crc_r;
    ok_nxt    = ok_r;
    size_nxt  = size_r;
    pcrc_nxt  = pcrc_r;
    flags_nxt = flags_r;
    count_nxt = count_r;
    free_nxt  = free_r;
    used_nxt  = used_r;
    scan_nxt  = scan_r;
    status    = ST_READ;
    case (s1_req.func)
      FUNC_START: begin
        count_nxt = '0;
        used_nxt  = '0;
        free_nxt  = '0;
        addr_nxt  = '0;
        widx_nxt  = '0;
        crc_nxt   = '1;
        ok_nxt    = 1'b1;
        if (s1_req.device_size == 32'd0 || !s1_req.device_present) begin
          scan_nxt  = 1'b0;
          limit_nxt = '0;
          status    = ST_FAIL;
        end else begin
          limit_nxt = clip;
          scan_nxt  = (clip != 32'd0);
          status    = (clip != 32'd0) ? ST_READ : ST_DONE;
        end
      end
      FUNC_FAIL: begin
        if (scan_r) begin
          scan_nxt = 1'b0;
          widx_nxt = '0;
          crc_nxt  = '1;
          ok_nxt   = 1'b1;
          status   = ST_FAIL;
        end
      end
      FUNC_WORD: begin
        if (scan_r && widx_r != WORD_HDR_CRC) begin
          crc_nxt  = crc_step(crc_r, w);
          widx_nxt = widx_r + 4'd1;
          case (widx_r)
            WORD_MAGIC_A: if (w != MAGIC_A) ok_nxt = 1'b0;
            WORD_MAGIC_B: if (w != MAGIC_B) ok_nxt = 1'b0;
            WORD_VERSION: if (w != fmt_ver_r) ok_nxt = 1'b0;
            WORD_SIZE:    size_nxt  = w;
            WORD_CRC:     pcrc_nxt  = w;
            WORD_FLAGS:   flags_nxt = w;
            default:      ;
          endcase
        end else if (scan_r) begin
          if (hdr_valid) begin
            addr_nxt = addr_ext[32:0];
            free_nxt = addr_ext[32:0];
          end else begin
            addr_nxt = addr_r + 33'(SECTOR_BYTES);
          end
          if (rec) begin
            count_nxt = count_r + 6'd1;
            used_nxt  = used_r + size_r;
          end
          widx_nxt = '0;
          crc_nxt  = '1;
          ok_nxt   = 1'b1;
          scan_nxt = (addr_nxt < {1'b0, limit_r});
          status   = scan_nxt ? ST_READ : ST_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res                   = '0;
    res.scan_status       = status;
    res.next_addr         = addr_nxt;
    res.file_count        = count_nxt;
    res.free_base         = free_nxt;
    res.used_total        = used_nxt;
    if (s1_req.func == FUNC_WORD && rec) begin
      res.entry_recorded    = 1'b1;
      res.entry_index       = count_r[4:0];
      res.entry_header_addr = addr_r[31:0];
      res.entry_data_addr   = {1'b0, addr_r[31:0]} + 33'(HDR_BYTES);
      res.entry_size        = size_r;
      res.entry_crc         = pcrc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsv_base_r <= 32'h00FF_0000;
      fmt_ver_r  <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESERVED_BASE:  rsv_base_r <= cfg_data;
        REG_FORMAT_VERSION: fmt_ver_r  <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      limit_r <= '0;
      widx_r  <= '0;
      crc_r   <= '1;
      ok_r    <= 1'b1;
      size_r  <= '0;
      pcrc_r  <= '0;
      flags_r <= '0;
      count_r <= '0;
      free_r  <= '0;
      used_r  <= '0;
      scan_r  <= 1'b0;
    end else if (take) begin
      addr_r  <= addr_nxt;
      limit_r <= limit_nxt;
      widx_r  <= widx_nxt;
      crc_r   <= crc_nxt;
      ok_r    <= ok_nxt;
      size_r  <= size_nxt;
      pcrc_r  <= pcrc_nxt;
      flags_r <= flags_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
      used_r  <= used_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule

/* hw/rtl/fhs_out_reg.sv */
// Result register of the flash file header scanner.
module fhs_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_load,
  input  fhs_pkg::res_t res_in,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          out_ready,
  output fhs_pkg::res_t res_out
);
  import fhs_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign out_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (res_load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
